// ===== hdl/tsid_pkg.sv =====
`timescale 1ns / 1ps

package tsid_pkg;

  localparam int SEQ_BITS_DEF    = 12;
  localparam int WORKER_BITS_DEF = 6;
  localparam int CENTER_BITS_DEF = 4;
  localparam int TIME_BITS_DEF   = 41;

  localparam int NOW_W     = 41;
  localparam int ID_W      = 63;
  localparam int STATUS_W  = 2;
  localparam int WORKER_W  = 6;
  localparam int CENTER_W  = 4;
  localparam int CFG_IDX_W = 8;
  localparam int CFG_DAT_W = 8;

  localparam logic [STATUS_W-1:0] ST_OK   = 2'd0;
  localparam logic [STATUS_W-1:0] ST_BACK = 2'd1;
  localparam logic [STATUS_W-1:0] ST_BUSY = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_WORKER = 8'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CENTER = 8'd1;

  typedef struct packed {
    logic [ID_W-1:0]     id;
    logic [STATUS_W-1:0] status;
  } result_t;

endpackage

// ===== hdl/tsid_core.sv =====
`timescale 1ns / 1ps

module tsid_core #(
  parameter int SEQ_BITS    = tsid_pkg::SEQ_BITS_DEF,
  parameter int WORKER_BITS = tsid_pkg::WORKER_BITS_DEF,
  parameter int CENTER_BITS = tsid_pkg::CENTER_BITS_DEF,
  parameter int TIME_BITS   = tsid_pkg::TIME_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          step,
  input  logic                          op,
  input  logic [tsid_pkg::NOW_W-1:0]    now_ms,
  input  logic [tsid_pkg::WORKER_W-1:0] worker_id,
  input  logic [tsid_pkg::CENTER_W-1:0] center_id,
  output logic                          res_valid,
  output tsid_pkg::result_t             res
);

  localparam int PACK_W = TIME_BITS + CENTER_BITS + WORKER_BITS + SEQ_BITS;

  logic [TIME_BITS-1:0] last_time_r, last_time_nxt;
  logic                 time_seen_r, time_seen_nxt;
  logic [SEQ_BITS-1:0]  seq_r, seq_nxt;
  logic                 held_r, held_nxt;

  logic [TIME_BITS-1:0] now_t;
  logic [SEQ_BITS-1:0]  seq_inc;
  logic [SEQ_BITS-1:0]  seq_out;
  logic [PACK_W-1:0]    packed_id;

  assign now_t     = TIME_BITS'(now_ms);
  assign seq_inc   = seq_r + SEQ_BITS'(1);
  assign packed_id = {now_t, CENTER_BITS'(center_id), WORKER_BITS'(worker_id), seq_out};

  always_comb begin
    last_time_nxt = last_time_r;
    time_seen_nxt = time_seen_r;
    seq_nxt       = seq_r;
    held_nxt      = held_r;
    seq_out       = '0;
    res_valid     = 1'b0;
    res.status    = tsid_pkg::ST_OK;
    res.id        = '0;
    priority if (held_r) begin
      if (now_t > last_time_r) begin
        last_time_nxt = now_t;
        seq_nxt       = '0;
        held_nxt      = 1'b0;
        res_valid     = 1'b1;
        res.id        = tsid_pkg::ID_W'(packed_id);
      end else if (op) begin
        res_valid  = 1'b1;
        res.status = tsid_pkg::ST_BUSY;
      end
    end else if (op) begin
      if (time_seen_r && now_t < last_time_r) begin
        res_valid  = 1'b1;
        res.status = tsid_pkg::ST_BACK;
      end else if (time_seen_r && now_t == last_time_r) begin
        seq_nxt = seq_inc;
        seq_out = seq_inc;
        if (seq_inc == '0) begin
          held_nxt = 1'b1;
        end else begin
          res_valid = 1'b1;
          res.id    = tsid_pkg::ID_W'(packed_id);
        end
      end else begin
        seq_nxt       = '0;
        last_time_nxt = now_t;
        time_seen_nxt = 1'b1;
        res_valid     = 1'b1;
        res.id        = tsid_pkg::ID_W'(packed_id);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_time_r <= '0;
      time_seen_r <= 1'b0;
      seq_r       <= '0;
      held_r      <= 1'b0;
    end else if (step) begin
      last_time_r <= last_time_nxt;
      time_seen_r <= time_seen_nxt;
      seq_r       <= seq_nxt;
      held_r      <= held_nxt;
    end
  end

endmodule

// ===== hdl/timestamp_sequence_id_generator.sv =====
`timescale 1ns / 1ps
// Path from input transfer to result transfer: input register, then result register.
// Throughput: one item per cycle, sustained while out_tready stays high.
// Items that yield no result (updates while not held or with no newer time, sequence wrap) are consumed without output.
// Reset: rst_n synchronous active low; clears valid flags, worker and center ids, last time, sequence and hold.

module timestamp_sequence_id_generator #(
  parameter int SEQ_BITS    = tsid_pkg::SEQ_BITS_DEF,
  parameter int WORKER_BITS = tsid_pkg::WORKER_BITS_DEF,
  parameter int CENTER_BITS = tsid_pkg::CENTER_BITS_DEF,
  parameter int TIME_BITS   = tsid_pkg::TIME_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  input  logic [47:0]                    in_tdata,   // [40:0] now_ms
  input  logic                           in_tuser,   // [0] op
  output logic                           out_tvalid,
  input  logic                           out_tready,
  output logic [63:0]                    out_tdata,  // [62:0] id_value
  output logic [tsid_pkg::STATUS_W-1:0]  out_tuser,  // [1:0] status
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [tsid_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [tsid_pkg::CFG_DAT_W-1:0] cfg_data
);

  logic                          in_v_r;
  logic                          op_r;
  logic [tsid_pkg::NOW_W-1:0]    now_r;
  logic                          out_v_r;
  tsid_pkg::result_t             out_r;
  logic [tsid_pkg::WORKER_W-1:0] worker_r;
  logic [tsid_pkg::CENTER_W-1:0] center_r;

  logic              out_room;
  logic              proc;
  logic              res_valid;
  tsid_pkg::result_t res;

  assign out_room  = !out_v_r || out_tready;
  assign proc      = in_v_r && out_room;
  assign in_tready = !in_v_r || proc;
  assign cfg_ready = 1'b1;

  assign out_tvalid = out_v_r;
  assign out_tdata  = {1'b0, out_r.id};
  assign out_tuser  = out_r.status;

  tsid_core #(
    .SEQ_BITS   (SEQ_BITS),
    .WORKER_BITS(WORKER_BITS),
    .CENTER_BITS(CENTER_BITS),
    .TIME_BITS  (TIME_BITS)
  ) u_core (
    .clk      (clk),
    .rst_n    (rst_n),
    .step     (proc),
    .op       (op_r),
    .now_ms   (now_r),
    .worker_id(worker_r),
    .center_id(center_r),
    .res_valid(res_valid),
    .res      (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      worker_r <= '0;
      center_r <= '0;
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index == tsid_pkg::CFG_WORKER) begin
        worker_r <= cfg_data[tsid_pkg::WORKER_W-1:0];
      end else if (cfg_index == tsid_pkg::CFG_CENTER) begin
        center_r <= cfg_data[tsid_pkg::CENTER_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else if (in_tready) begin
      in_v_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      op_r  <= in_tuser;
      now_r <= in_tdata[tsid_pkg::NOW_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (out_room) begin
      out_v_r <= proc && res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (proc && res_valid) begin
      out_r <= res;
    end
  end

endmodule

// ===== hdl/tsid_checker.sv =====
`timescale 1ns / 1ps

module tsid_checker (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          in_tready,
  input logic                          out_tvalid,
  input logic                          out_tready,
  input logic [63:0]                   out_tdata,
  input logic [tsid_pkg::STATUS_W-1:0] out_tuser
);

  // hold a stalled result
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("stalled result changed");

  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tuser == tsid_pkg::ST_OK || out_tuser == tsid_pkg::ST_BACK ||
                    out_tuser == tsid_pkg::ST_BUSY))
    else $error("bad status code");

  a_err_zero_id: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser != tsid_pkg::ST_OK |-> out_tdata == 64'd0)
    else $error("error result carries nonzero id");

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

  a_ready_only_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> out_tvalid && !out_tready)
    else $error("input stalled without output backpressure");

endmodule

bind timestamp_sequence_id_generator tsid_checker u_tsid_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_tready (in_tready),
  .out_tvalid(out_tvalid),
  .out_tready(out_tready),
  .out_tdata (out_tdata),
  .out_tuser (out_tuser)
);

// ===== dv/tsid_tb_pkg.sv =====
`timescale 1ns / 1ps

package tsid_tb_pkg;

  typedef enum logic {
    OP_UPDATE  = 1'b0,
    OP_REQUEST = 1'b1
  } op_e;

endpackage

// ===== dv/id_stream_checker.sv =====
`timescale 1ns / 1ps

module id_stream_checker (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_tvalid,
  input  logic                          in_tready,
  input  logic [47:0]                   in_tdata,   // [40:0] now_ms
  input  logic                          in_tuser,   // [0] op
  input  logic                          out_tvalid,
  input  logic                          out_tready,
  input  logic [63:0]                   out_tdata,  // [62:0] id_value
  input  logic [tsid_pkg::STATUS_W-1:0] out_tuser,  // [1:0] status
  input  logic                          cfg_valid,
  input  logic                          cfg_ready,
  input  logic [tsid_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [tsid_pkg::CFG_DAT_W-1:0] cfg_data,
  output int                            mismatches,
  output int                            owed,
  output int                            ids_ok,
  output int                            backwards_seen,
  output int                            busy_seen,
  output int                            wraps_seen
);
  import tsid_pkg::*;
  import tsid_tb_pkg::*;

  localparam int MS_W  = TIME_BITS_DEF;
  localparam int SEQ_W = SEQ_BITS_DEF;

  logic [WORKER_W-1:0] worker;
  logic [CENTER_W-1:0] center;
  logic [MS_W-1:0]     last_ms;
  logic                ms_seen;
  logic                held;
  logic [SEQ_W-1:0]    seq;
  result_t             owed_ids[$];

  function automatic logic [ID_W-1:0] pack_id(input logic [MS_W-1:0] ms,
                                              input logic [SEQ_W-1:0] s);
    return ID_W'({ms, center, worker, s});
  endfunction

  task automatic owe(input logic [ID_W-1:0] id, input logic [STATUS_W-1:0] st);
    result_t r;
    r.id     = id;
    r.status = st;
    owed_ids.push_back(r);
    case (st)
      ST_OK:   ids_ok++;
      ST_BACK: backwards_seen++;
      default: busy_seen++;
    endcase
  endtask

  task automatic predict_id(input op_e op, input logic [MS_W-1:0] now);
    if (held) begin
      if (now > last_ms) begin
        last_ms = now;
        seq     = '0;
        held    = 1'b0;
        owe(pack_id(now, '0), ST_OK);
      end else if (op == OP_REQUEST) begin
        owe('0, ST_BUSY);
      end
    end else if (op == OP_REQUEST) begin
      if (ms_seen && now < last_ms) begin
        owe('0, ST_BACK);
      end else if (ms_seen && now == last_ms) begin
        seq = seq + 1'b1;
        if (seq == '0) begin
          held = 1'b1;
          wraps_seen++;
        end else begin
          owe(pack_id(now, seq), ST_OK);
        end
      end else begin
        seq     = '0;
        last_ms = now;
        ms_seen = 1'b1;
        owe(pack_id(now, '0), ST_OK);
      end
    end
  endtask

  always @(posedge clk) begin : watch
    result_t want;
    if (!rst_n) begin
      worker         = '0;
      center         = '0;
      last_ms        = '0;
      ms_seen        = 1'b0;
      held           = 1'b0;
      seq            = '0;
      mismatches     = 0;
      ids_ok         = 0;
      backwards_seen = 0;
      busy_seen      = 0;
      wraps_seen     = 0;
      owed_ids.delete();
    end else begin
      if (in_tvalid && in_tready)
        predict_id(op_e'(in_tuser), in_tdata[MS_W-1:0]);
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_WORKER: worker = cfg_data[WORKER_W-1:0];
          CFG_CENTER: center = cfg_data[CENTER_W-1:0];
          default: ;
        endcase
      end
      if (out_tvalid && out_tready) begin
        if (owed_ids.size() == 0) begin
          if (mismatches < 10)
            $display("%0t: unexpected result id=%h status=%0d", $time,
                     out_tdata[ID_W-1:0], out_tuser);
          mismatches++;
        end else begin
          want = owed_ids.pop_front();
          if (out_tdata[ID_W-1:0] !== want.id || out_tuser !== want.status) begin
            if (mismatches < 10)
              $display("%0t: mismatch expected id=%h status=%0d, got id=%h status=%0d",
                       $time, want.id, want.status, out_tdata[ID_W-1:0], out_tuser);
            mismatches++;
          end
        end
      end
    end
    owed = owed_ids.size();
  end

endmodule

// ===== dv/testbench.sv =====
`timescale 1ns / 1ps

module testbench;

  localparam int MS_W = tsid_pkg::TIME_BITS_DEF;
  localparam logic [MS_W-1:0] MS_MAX = '1;
  localparam int QUIET_LIMIT = 2000;
  localparam logic [tsid_pkg::CFG_IDX_W-1:0] CFG_UNUSED_LO = tsid_pkg::CFG_CENTER + 1'b1;
  localparam logic [tsid_pkg::CFG_IDX_W-1:0] CFG_UNUSED_HI = '1;

  logic                           clk;
  logic                           rst_n;
  logic                           in_tvalid;
  logic                           in_tready;
  logic [47:0]                    in_tdata;   // [40:0] now_ms
  logic                           in_tuser;   // [0] op
  logic                           out_tvalid;
  logic                           out_tready;
  logic [63:0]                    out_tdata;  // [62:0] id_value
  logic [tsid_pkg::STATUS_W-1:0]  out_tuser;  // [1:0] status
  logic                           cfg_valid;
  logic                           cfg_ready;
  logic [tsid_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [tsid_pkg::CFG_DAT_W-1:0] cfg_data;

  int mismatches, owed, ids_ok, backwards_seen, busy_seen, wraps_seen;
  int items_sent;
  logic gaps_on, stalls_on;
  logic [MS_W-1:0] clock_ms;

  timestamp_sequence_id_generator u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  id_stream_checker u_check (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_tvalid      (in_tvalid),
    .in_tready      (in_tready),
    .in_tdata       (in_tdata),
    .in_tuser       (in_tuser),
    .out_tvalid     (out_tvalid),
    .out_tready     (out_tready),
    .out_tdata      (out_tdata),
    .out_tuser      (out_tuser),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .mismatches     (mismatches),
    .owed           (owed),
    .ids_ok         (ids_ok),
    .backwards_seen (backwards_seen),
    .busy_seen      (busy_seen),
    .wraps_seen     (wraps_seen)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic int pick_pause();
    int r;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [MS_W-1:0] any_ms();
    return MS_W'({$urandom, $urandom});
  endfunction

  task automatic send(input tsid_tb_pkg::op_e op, input logic [MS_W-1:0] ms);
    int gap;
    gap = gaps_on ? pick_pause() : 0;
    if (gap > 0) begin
      @(negedge clk);
      in_tvalid = 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_tvalid = 1'b1;
    in_tuser  = op;
    in_tdata  = {{(48 - MS_W){1'b0}}, ms};
    do @(posedge clk); while (!in_tready);
    items_sent++;
  endtask

  // hold the sender until every owed result has come back
  task automatic settle();
    @(negedge clk);
    in_tvalid = 1'b0;
    while (owed != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_reg(input logic [tsid_pkg::CFG_IDX_W-1:0] idx,
                           input logic [tsid_pkg::CFG_DAT_W-1:0] data);
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data  = data;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic churn(input int count, input logic [MS_W-1:0] base);
    int r;
    logic [MS_W-1:0] ms;
    clock_ms = base;
    for (int i = 0; i < count; i++) begin
      if (i == count / 2)
        settle();
      r = $urandom_range(0, 99);
      if (r < 50) begin
        send(tsid_tb_pkg::OP_REQUEST, clock_ms);
      end else if (r < 65) begin
        clock_ms += MS_W'($urandom_range(1, 3));
        send(tsid_tb_pkg::OP_REQUEST, clock_ms);
      end else if (r < 70) begin
        clock_ms += MS_W'($urandom_range(1, 1 << 24));
        send(tsid_tb_pkg::OP_REQUEST, clock_ms);
      end else if (r < 82) begin
        send(tsid_tb_pkg::OP_UPDATE, any_ms());
      end else if (r < 88) begin
        send(tsid_tb_pkg::OP_REQUEST, clock_ms - MS_W'($urandom_range(1, 500)));
      end else if (r < 94) begin
        ms = any_ms();
        send(tsid_tb_pkg::OP_REQUEST, (ms < clock_ms) ? ms : ms % clock_ms);
      end else begin
        send(tsid_tb_pkg::OP_UPDATE, clock_ms + MS_W'($urandom_range(0, 2)));
      end
    end
  endtask

  initial begin : out_side
    int hold_left;
    hold_left  = 0;
    out_tready = 1'b1;
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        out_tready = 1'b0;
        hold_left--;
      end else begin
        out_tready = 1'b1;
        if (stalls_on)
          hold_left = pick_pause();
      end
    end
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || (cfg_valid && cfg_ready))
        quiet = 0;
      else
        quiet++;
    end
    $display("RESULT: ERROR");
    $finish;
  end

  initial begin : stimulus
    in_tvalid  = 1'b0;
    in_tdata   = '0;
    in_tuser   = tsid_tb_pkg::OP_UPDATE;
    cfg_valid  = 1'b0;
    cfg_index  = '0;
    cfg_data   = '0;
    rst_n      = 1'b0;
    gaps_on    = 1'b1;
    stalls_on  = 1'b1;
    items_sent = 0;
    clock_ms   = '0;
    repeat (6) @(negedge clk);
    rst_n = 1'b1;

    write_reg(tsid_pkg::CFG_WORKER, 8'hFF);
    write_reg(tsid_pkg::CFG_CENTER, 8'hFF);
    send(tsid_tb_pkg::OP_UPDATE, any_ms());
    send(tsid_tb_pkg::OP_UPDATE, MS_MAX);
    send(tsid_tb_pkg::OP_REQUEST, '0);
    send(tsid_tb_pkg::OP_REQUEST, '0);
    send(tsid_tb_pkg::OP_REQUEST, '0);
    send(tsid_tb_pkg::OP_UPDATE, '0);
    send(tsid_tb_pkg::OP_REQUEST, MS_W'(10));
    send(tsid_tb_pkg::OP_REQUEST, MS_W'(9));
    send(tsid_tb_pkg::OP_REQUEST, '0);
    send(tsid_tb_pkg::OP_REQUEST, MS_W'(10));
    send(tsid_tb_pkg::OP_UPDATE, MS_MAX);
    send(tsid_tb_pkg::OP_REQUEST, MS_W'(11));
    send(tsid_tb_pkg::OP_REQUEST, MS_W'(11));
    settle();

    write_reg(CFG_UNUSED_LO, 8'hA5);
    write_reg(CFG_UNUSED_HI, 8'hFF);

    gaps_on   = 1'b1;
    stalls_on = 1'b1;
    write_reg(tsid_pkg::CFG_WORKER, 8'h00);
    write_reg(tsid_pkg::CFG_CENTER, 8'h0F);
    churn(240, MS_W'(1) << 20);
    settle();

    gaps_on   = 1'b0;
    stalls_on = 1'b0;
    write_reg(tsid_pkg::CFG_WORKER, 8'h3F);
    write_reg(tsid_pkg::CFG_CENTER, 8'hF0);
    churn(240, MS_W'(1) << 38);
    settle();

    gaps_on   = 1'b1;
    stalls_on = 1'b1;
    write_reg(tsid_pkg::CFG_WORKER, tsid_pkg::CFG_DAT_W'($urandom));
    write_reg(tsid_pkg::CFG_CENTER, tsid_pkg::CFG_DAT_W'($urandom));
    churn(240, (MS_W'(1) << 39) + MS_W'($urandom_range(0, 99999)));
    settle();

    write_reg(tsid_pkg::CFG_WORKER, tsid_pkg::CFG_DAT_W'($urandom));
    write_reg(tsid_pkg::CFG_CENTER, tsid_pkg::CFG_DAT_W'($urandom));
    write_reg(CFG_UNUSED_LO + 1'b1, tsid_pkg::CFG_DAT_W'($urandom));
    churn(240, (MS_W'(1) << 40) + (MS_W'(1) << 39));
    settle();

    write_reg(tsid_pkg::CFG_WORKER, 8'h3F);
    write_reg(tsid_pkg::CFG_CENTER, 8'h0F);
    send(tsid_tb_pkg::OP_REQUEST, MS_MAX);
    send(tsid_tb_pkg::OP_REQUEST, MS_MAX);
    send(tsid_tb_pkg::OP_REQUEST, MS_MAX - 1'b1);
    send(tsid_tb_pkg::OP_UPDATE, '0);
    settle();
    repeat (6) @(negedge clk);

    $display("Ran %0d items over six register settings: %0d ids, %0d clock-backwards,",
             items_sent, ids_ok, backwards_seen);
    $display("%0d busy answers and %0d sequence wraps.",
             busy_seen, wraps_seen);
    if (mismatches == 0 && owed == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end

endmodule

// ===== files.f =====
hdl/tsid_pkg.sv
hdl/tsid_core.sv
hdl/timestamp_sequence_id_generator.sv
hdl/tsid_checker.sv
dv/tsid_tb_pkg.sv
dv/id_stream_checker.sv
dv/testbench.sv
